// ----- hdl/fbp_pkg.sv -----
// Shared types, codes and constants of the fixed block pool.
package fbp_pkg;

   localparam int DEF_STACK_DEPTH = 256;

   localparam int ADDR_W  = 32;
   localparam int LEN_W   = 32;
   localparam int SIZE_W  = 16;
   localparam int FREE_W  = 9;
   localparam int USED_W  = 16;
   localparam int MODE_W  = 2;

   localparam logic [SIZE_W-1:0] ITEM_SIZE_RESET = 16'd4;
   localparam logic [SIZE_W-1:0] MIN_ITEM_SIZE   = 16'd4;
   localparam logic [USED_W-1:0] USED_MAX        = 16'hFFFF;

   localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd2;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_REJECT = 2'd2,
      ST_DROP   = 2'd3
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic       load;         // latch buffer start and length for carving
      logic       pop;          // pop top entry, register its address
      logic       push_req;     // push request address if room
      logic       carve_push;   // push current carve address, advance
      logic       used_inc;
      logic       used_dec;
      logic       set_status;
      status_type status;
      logic       blk_sel;      // result carries popped address
      logic       out_load;     // capture result into output register
   } fbp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
      logic size_ok;            // item size and request length allow an add
      logic carve_more;         // another whole block left in buffer
   } fbp_stat_type;

endpackage

// ----- hdl/fbp_dpath.sv -----
// Datapath of the fixed block pool: free stack memory, counters, carve unit, result register.
module fbp_dpath #(
   parameter int STACK_DEPTH = fbp_pkg::DEF_STACK_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [fbp_pkg::SIZE_W-1:0]  csr_wdata,
   input  logic [fbp_pkg::ADDR_W-1:0]  req_address,
   input  logic [fbp_pkg::LEN_W-1:0]   req_length,
   input  fbp_pkg::fbp_cmd_type        cmd,
   output fbp_pkg::fbp_stat_type       stat,
   output logic [fbp_pkg::ADDR_W-1:0]  rsp_block_address,
   output fbp_pkg::status_type         rsp_status,
   output logic [fbp_pkg::FREE_W-1:0]  rsp_free_items,
   output logic [fbp_pkg::USED_W-1:0]  rsp_used_items
);
   import fbp_pkg::*;

   localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int TOP_W = $clog2(STACK_DEPTH + 1);
   localparam logic [TOP_W-1:0] TOP_FULL = TOP_W'(STACK_DEPTH);

   logic [ADDR_W-1:0] stack_mem [STACK_DEPTH];

   logic [SIZE_W-1:0] item_size_ff;
   logic [TOP_W-1:0]  top_ff, top_in;
   logic [USED_W-1:0] used_ff, used_in;
   logic [ADDR_W-1:0] carve_addr_ff, carve_addr_in;
   logic [LEN_W-1:0]  carve_rem_ff, carve_rem_in;
   logic [ADDR_W-1:0] rd_data_ff;
   status_type        status_ff;
   logic              blk_sel_ff;

   logic [ADDR_W-1:0] out_addr_ff;
   status_type        out_status_ff;
   logic [FREE_W-1:0] out_free_ff;
   logic [USED_W-1:0] out_used_ff;

   logic              do_push;
   logic [ADDR_W-1:0] push_data;
   logic [LEN_W-1:0]  item_size_ext;
   logic [IDX_W-1:0]  pop_idx;

   assign item_size_ext = LEN_W'(item_size_ff);
   assign pop_idx       = IDX_W'(top_ff - TOP_W'(1));

   assign stat.empty      = (top_ff == '0);
   assign stat.full       = (top_ff == TOP_FULL);
   assign stat.size_ok    = (item_size_ff >= MIN_ITEM_SIZE) && (req_length >= item_size_ext);
   assign stat.carve_more = (carve_rem_ff >= item_size_ext);

   assign do_push   = ((cmd.push_req && !stat.full) || cmd.carve_push);
   assign push_data = cmd.carve_push ? carve_addr_ff : req_address;

   always_comb begin
      top_in        = top_ff;
      used_in       = used_ff;
      carve_addr_in = carve_addr_ff;
      carve_rem_in  = carve_rem_ff;
      if (cmd.pop) begin
         top_in = top_ff - TOP_W'(1);
      end
      if (do_push) begin
         top_in = top_ff + TOP_W'(1);
      end
      if (cmd.used_inc && (used_ff != USED_MAX)) begin
         used_in = used_ff + USED_W'(1);
      end
      if (cmd.used_dec && (used_ff != '0)) begin
         used_in = used_ff - USED_W'(1);
      end
      if (cmd.load) begin
         carve_addr_in = req_address;
         carve_rem_in  = req_length;
      end else if (cmd.carve_push) begin
         carve_addr_in = carve_addr_ff + ADDR_W'(item_size_ff);
         carve_rem_in  = carve_rem_ff - item_size_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_size_ff <= ITEM_SIZE_RESET;
         top_ff       <= '0;
         used_ff      <= '0;
      end else begin
         if (csr_we) begin
            item_size_ff <= csr_wdata;
         end
         top_ff  <= top_in;
         used_ff <= used_in;
      end
   end

   // stack memory: one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (do_push) begin
         stack_mem[top_ff[IDX_W-1:0]] <= push_data;
      end
      if (cmd.pop) begin
         rd_data_ff <= stack_mem[pop_idx];
      end
   end

   always_ff @(posedge clock) begin
      carve_addr_ff <= carve_addr_in;
      carve_rem_ff  <= carve_rem_in;
      if (cmd.set_status) begin
         status_ff  <= cmd.status;
         blk_sel_ff <= cmd.blk_sel;
      end
      if (cmd.out_load) begin
         out_addr_ff   <= blk_sel_ff ? rd_data_ff : '0;
         out_status_ff <= status_ff;
         out_free_ff   <= FREE_W'(top_ff);
         out_used_ff   <= used_ff;
      end
   end

   assign rsp_block_address = out_addr_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_free_items    = out_free_ff;
   assign rsp_used_items    = out_used_ff;

endmodule

// ----- hdl/fbp_ctrl.sv -----
// Controller of the fixed block pool: request sequencing and result handshake.
module fbp_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [fbp_pkg::MODE_W-1:0]  req_mode,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  fbp_pkg::fbp_stat_type       stat,
   output fbp_pkg::fbp_cmd_type        cmd
);
   import fbp_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CARVE,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.status   = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.set_status = 1'b1;
               state_in       = S_FINISH;
               unique case (req_mode)
                  MODE_ALLOC: begin
                     if (stat.empty) begin
                        cmd.status = ST_EMPTY;
                     end else begin
                        cmd.pop      = 1'b1;
                        cmd.used_inc = 1'b1;
                        cmd.blk_sel  = 1'b1;
                     end
                  end
                  MODE_FREE: begin
                     // the block leaves the user even when its address is dropped
                     cmd.push_req = 1'b1;
                     cmd.used_dec = 1'b1;
                     cmd.status   = stat.full ? ST_DROP : ST_OK;
                  end
                  MODE_ADD: begin
                     if (stat.size_ok) begin
                        cmd.load = 1'b1;
                        state_in = S_CARVE;
                     end else begin
                        cmd.status = ST_REJECT;
                     end
                  end
                  default: begin
                     cmd.status = ST_OK;
                  end
               endcase
            end
         end
         S_CARVE: begin
            if (stat.carve_more && !stat.full) begin
               cmd.carve_push = 1'b1;
            end else begin
               cmd.set_status = 1'b1;
               cmd.status     = stat.carve_more ? ST_DROP : ST_OK;
               state_in       = S_FINISH;
            end
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- hdl/fixed_block_pool_free_stack.sv -----
// Top level of the fixed block pool with a last-in-first-out free stack.
//
//   channel   direction  handshake            payload
//   req       in         req_tvalid/tready    tdata: address, length; tuser: mode
//   rsp       out        rsp_tvalid/tready    tdata: block_address, free_items, used_items;
//                                             tuser: status
//   csr       in         csr_we               csr_wdata: item_size
//
// Allocate, free and rejected or no-op requests are decided in the idle state, with any stack
// memory access there, and then load the output register in the finish state. An add pushes one
// block per cycle, one stack memory write each, until it sees the end of the buffer or a full stack.
// Reset clears the counts and sets item_size to 4; the stack memory is not cleared.
// A stalled result holds the finished request in the controller until the output frees.
module fixed_block_pool_free_stack #(
   parameter int STACK_DEPTH = fbp_pkg::DEF_STACK_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,    // address[31:0], length[63:32]
   input  logic [1:0]  req_tuser,    // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // block_address[31:0], free_items[40:32],
                                     // used_items[56:41], zero[63:57]
   output logic [1:0]  rsp_tuser,    // status[1:0]
   input  logic        csr_we,
   input  logic [15:0] csr_wdata     // item_size
);
   import fbp_pkg::*;

   fbp_cmd_type       cmd;
   fbp_stat_type      stat;
   logic [ADDR_W-1:0] blk_addr;
   status_type        status;
   logic [FREE_W-1:0] free_items;
   logic [USED_W-1:0] used_items;

   fbp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   fbp_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_address       (req_tdata[31:0]),
      .req_length        (req_tdata[63:32]),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_block_address (blk_addr),
      .rsp_status        (status),
      .rsp_free_items    (free_items),
      .rsp_used_items    (used_items)
   );

   assign rsp_tdata = {7'd0, used_items, free_items, blk_addr};
   assign rsp_tuser = status;

endmodule
